// File: hw/rtl/nor_flash_command_interface_top_assert.svh
// Assertion macros shared by the checker of the NOR flash command block.
// No dependencies; included by the checker file.
`ifndef NOR_FLASH_COMMAND_INTERFACE_TOP_ASSERT_SVH
`define NOR_FLASH_COMMAND_INTERFACE_TOP_ASSERT_SVH

// Clocked property, ignored while reset is high.
`define NFC_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define NFC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// File: hw/rtl/nfc_pkg.sv
// Shared constants, types and helpers of the NOR flash command block.
// No dependencies; used by the decoder, the top level and the checker.
`default_nettype none
package nfc_pkg;
  localparam int ADDR_BITS       = 20;
  localparam int BLOCK_ADDR_BITS = 16;
  localparam int BUFFER_WORDS    = 512;
  localparam int ARRAY_WORDS     = 1 << ADDR_BITS;
  localparam int NUM_BLOCKS      = 1 << (ADDR_BITS - BLOCK_ADDR_BITS);
  localparam int BLK_IW          = (ADDR_BITS > BLOCK_ADDR_BITS) ?
                                   (ADDR_BITS - BLOCK_ADDR_BITS) : 1;
  localparam int BUF_AW          = $clog2(BUFFER_WORDS);
  localparam int CNT_W           = $clog2(BUFFER_WORDS + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [15:0]          word_t;
  typedef logic [4:0]           mode_t;

  // Command decoder modes, as reported on the result channel.
  localparam mode_t M_READ   = 5'd0;
  localparam mode_t M_UL1    = 5'd1;
  localparam mode_t M_UL2    = 5'd2;
  localparam mode_t M_AUTO   = 5'd3;
  localparam mode_t M_ESETUP = 5'd4;
  localparam mode_t M_EUL1   = 5'd5;
  localparam mode_t M_EUL2   = 5'd6;
  localparam mode_t M_BCOUNT = 5'd7;
  localparam mode_t M_BLOAD  = 5'd8;
  localparam mode_t M_BCONF  = 5'd9;
  localparam mode_t M_ABORT  = 5'd10;
  localparam mode_t M_PROT   = 5'd11;
  localparam mode_t M_PPROG  = 5'd12;
  localparam mode_t M_PCLR   = 5'd13;
  localparam mode_t M_PEXIT  = 5'd14;
  localparam mode_t M_AUL1   = 5'd15;
  localparam mode_t M_AUL2   = 5'd16;

  // Bus access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Command codes and unlock addresses.
  localparam word_t CMD_UNLOCK1  = 16'h00AA;
  localparam word_t CMD_UNLOCK2  = 16'h0055;
  localparam word_t CMD_BUF_PROG = 16'h0025;
  localparam word_t CMD_CONFIRM  = 16'h0029;
  localparam word_t CMD_ERASE    = 16'h0030;
  localparam word_t CMD_SETUP    = 16'h0080;
  localparam word_t CMD_AUTOSEL  = 16'h0090;
  localparam word_t CMD_PROT     = 16'h00C0;
  localparam word_t CMD_PSET     = 16'h00A0;
  localparam word_t CMD_ZERO     = 16'h0000;
  localparam word_t CMD_RESET    = 16'h00F0;
  localparam logic [10:0] UNLOCK_A = 11'h555;
  localparam logic [10:0] UNLOCK_B = 11'h2AA;

  // Autoselect offsets.
  localparam logic [7:0] AS_MFR  = 8'h00;
  localparam logic [7:0] AS_DEV  = 8'h01;
  localparam logic [7:0] AS_PROT = 8'h02;

  // Configuration register indexes.
  localparam logic CFG_MFR_ID = 1'b0;
  localparam logic CFG_DEV_ID = 1'b1;

  localparam word_t MFR_ID_RST = 16'h0089;
  localparam word_t DEV_ID_RST = 16'h227E;

  // Actions that a write command asks of the datapath.
  typedef struct packed {
    logic erase;
    logic commit;
    logic buf_wr;
    logic set_start;
    logic prot_set;
    logic prot_clear;
    logic lpw_data;
    logic lpw_ones;
    logic count_load;
    logic count_step;
  } cmd_act_t;

  function automatic logic [BLK_IW-1:0] block_of(addr_t a);
    return BLK_IW'(a >> BLOCK_ADDR_BITS);
  endfunction

  function automatic logic is_abort(mode_t m);
    return (m == M_ABORT) || (m == M_AUL1) || (m == M_AUL2);
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/nfc_req_if.sv
// Request channel interface: one bus access per transaction.
// No dependencies; the field widths are written as fixed numbers.
`default_nettype none
interface nfc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [19:0] word_addr;
  logic [15:0] wdata;
  modport source (output valid, op, word_addr, wdata, input ready);
  modport sink   (input valid, op, word_addr, wdata, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/nfc_rsp_if.sv
// Response channel interface: one result per transaction.
// No dependencies.
`default_nettype none
interface nfc_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] rdata;
  logic [4:0]  mode;
  logic        failed;
  modport source (output valid, rdata, mode, failed, input ready);
  modport sink   (input valid, rdata, mode, failed, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/nfc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none
module nfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/nfc_cmd.sv
// Write command decoder: next mode and datapath actions for one write.
// Depends on nfc_pkg.
`default_nettype none
module nfc_cmd (
  input  wire nfc_pkg::mode_t                 mode,
  input  wire nfc_pkg::addr_t                 addr,
  input  wire nfc_pkg::word_t                 data,
  input  wire nfc_pkg::addr_t                 buf_start,
  input  wire nfc_pkg::cnt_t                  buf_count,
  input  wire nfc_pkg::cnt_t                  buf_remaining,
  input  wire logic [nfc_pkg::NUM_BLOCKS-1:0] prot,
  output nfc_pkg::mode_t                      mode_next,
  output nfc_pkg::cmd_act_t                   act,
  output nfc_pkg::cnt_t                       remaining_next
);
  logic [10:0] lo;
  logic        ul_a;
  logic        ul_b;
  logic [nfc_pkg::ADDR_BITS:0] next_addr;
  nfc_pkg::addr_t end_addr;
  logic        bad_seq;
  logic        range_prot;

  assign lo   = 11'(addr);
  assign ul_a = (lo == nfc_pkg::UNLOCK_A);
  assign ul_b = (lo == nfc_pkg::UNLOCK_B);

  // Sequence check for buffer loads: next address, same page, room left.
  assign next_addr = {1'b0, buf_start} + (nfc_pkg::ADDR_BITS+1)'(buf_count);
  assign bad_seq   = ({1'b0, addr} != next_addr) ||
                     ((addr >> nfc_pkg::BUF_AW) != (buf_start >> nfc_pkg::BUF_AW)) ||
                     (buf_count >= nfc_pkg::CNT_W'(nfc_pkg::BUFFER_WORDS));

  // A buffer stays inside one page, so it lies within a single block.
  assign end_addr   = buf_start + nfc_pkg::ADDR_BITS'(buf_count) - nfc_pkg::ADDR_BITS'(1);
  assign range_prot = prot[nfc_pkg::block_of(buf_start)] | prot[nfc_pkg::block_of(end_addr)];

  always_comb begin
    mode_next      = mode;
    act            = '0;
    remaining_next = (buf_remaining != '0) ? buf_remaining - nfc_pkg::CNT_W'(1) : '0;
    case (mode)
      nfc_pkg::M_READ: begin
        mode_next = (data == nfc_pkg::CMD_UNLOCK1 && ul_a) ? nfc_pkg::M_UL1 : nfc_pkg::M_READ;
      end
      nfc_pkg::M_UL1: begin
        mode_next = (data == nfc_pkg::CMD_UNLOCK2 && ul_b) ? nfc_pkg::M_UL2 : nfc_pkg::M_READ;
      end
      nfc_pkg::M_UL2: begin
        if (data == nfc_pkg::CMD_BUF_PROG) begin
          mode_next = nfc_pkg::M_BCOUNT;
        end else if (ul_a && data == nfc_pkg::CMD_AUTOSEL) begin
          mode_next = nfc_pkg::M_AUTO;
        end else if (ul_a && data == nfc_pkg::CMD_SETUP) begin
          mode_next = nfc_pkg::M_ESETUP;
        end else if (ul_a && data == nfc_pkg::CMD_PROT) begin
          mode_next = nfc_pkg::M_PROT;
        end else begin
          mode_next = nfc_pkg::M_READ;
        end
      end
      nfc_pkg::M_AUTO: begin
        if (data == nfc_pkg::CMD_RESET) begin
          mode_next = nfc_pkg::M_READ;
        end
      end
      nfc_pkg::M_ESETUP: begin
        mode_next = (data == nfc_pkg::CMD_UNLOCK1 && ul_a) ? nfc_pkg::M_EUL1 : nfc_pkg::M_READ;
      end
      nfc_pkg::M_EUL1: begin
        mode_next = (data == nfc_pkg::CMD_UNLOCK2 && ul_b) ? nfc_pkg::M_EUL2 : nfc_pkg::M_READ;
      end
      nfc_pkg::M_EUL2: begin
        mode_next = nfc_pkg::M_READ;
        if (data == nfc_pkg::CMD_ERASE) begin
          act.lpw_ones = 1'b1;
          if (prot[nfc_pkg::block_of(addr)]) begin
            mode_next = nfc_pkg::M_ABORT;
          end else begin
            act.erase = 1'b1;
          end
        end
      end
      nfc_pkg::M_BCOUNT: begin
        if (data >= 16'(nfc_pkg::BUFFER_WORDS)) begin
          mode_next = nfc_pkg::M_ABORT;
        end else begin
          act.count_load = 1'b1;
          remaining_next = nfc_pkg::CNT_W'(data) + nfc_pkg::CNT_W'(1);
          mode_next      = nfc_pkg::M_BLOAD;
        end
      end
      nfc_pkg::M_BLOAD: begin
        if (buf_count != '0 && bad_seq) begin
          mode_next = nfc_pkg::M_ABORT;
        end else begin
          act.set_start  = (buf_count == '0);
          act.buf_wr     = 1'b1;
          act.lpw_data   = 1'b1;
          act.count_step = 1'b1;
          mode_next = (remaining_next == '0) ? nfc_pkg::M_BCONF : nfc_pkg::M_BLOAD;
        end
      end
      nfc_pkg::M_BCONF: begin
        if (data == nfc_pkg::CMD_CONFIRM && !range_prot) begin
          act.commit = 1'b1;
          mode_next  = nfc_pkg::M_READ;
        end else begin
          mode_next = nfc_pkg::M_ABORT;
        end
      end
      nfc_pkg::M_ABORT: begin
        mode_next = (data == nfc_pkg::CMD_UNLOCK1 && ul_a) ? nfc_pkg::M_AUL1 : nfc_pkg::M_ABORT;
      end
      nfc_pkg::M_AUL1: begin
        mode_next = (data == nfc_pkg::CMD_UNLOCK2 && ul_b) ? nfc_pkg::M_AUL2 : nfc_pkg::M_ABORT;
      end
      nfc_pkg::M_AUL2: begin
        mode_next = (data == nfc_pkg::CMD_RESET && ul_a) ? nfc_pkg::M_READ : nfc_pkg::M_ABORT;
      end
      nfc_pkg::M_PROT: begin
        if (data == nfc_pkg::CMD_PSET) begin
          mode_next = nfc_pkg::M_PPROG;
        end else if (data == nfc_pkg::CMD_SETUP) begin
          mode_next = nfc_pkg::M_PCLR;
        end else if (data == nfc_pkg::CMD_AUTOSEL) begin
          mode_next = nfc_pkg::M_PEXIT;
        end
      end
      nfc_pkg::M_PPROG: begin
        act.prot_set = (data == nfc_pkg::CMD_ZERO);
        mode_next    = nfc_pkg::M_PROT;
      end
      nfc_pkg::M_PCLR: begin
        act.prot_clear = (data == nfc_pkg::CMD_ERASE);
        mode_next      = nfc_pkg::M_PROT;
      end
      nfc_pkg::M_PEXIT: begin
        mode_next = (data == nfc_pkg::CMD_ZERO) ? nfc_pkg::M_READ : nfc_pkg::M_PROT;
      end
      default: begin
        mode_next = nfc_pkg::M_READ;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/nor_flash_command_interface_top.sv
// A request is captured on acceptance, decoded in the execute phase, and its result then registered.
// Requests are taken one at a time, after the array memory read and decode of the last one.
// A block erase then walks the block, one word a cycle (2**BLOCK_ADDR_BITS words);
// a buffered program commit walks the buffer, one array word a cycle.
// After reset a clearing pass writes every array word once (2**ADDR_BITS words)
// before the first request is accepted; configuration writes are taken throughout.
`default_nettype none
module nor_flash_command_interface_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  nfc_req_if.sink          req,
  nfc_rsp_if.source        rsp
);
  typedef enum logic [4:0] {
    PH_CLEAR  = 5'b00001,
    PH_IDLE   = 5'b00010,
    PH_EXEC   = 5'b00100,
    PH_ERASE  = 5'b01000,
    PH_COMMIT = 5'b10000
  } phase_t;

  phase_t                       phase;
  nfc_pkg::mode_t               mode;
  nfc_pkg::word_t               mfr_id;
  nfc_pkg::word_t               dev_id;
  logic [nfc_pkg::NUM_BLOCKS-1:0] prot;
  nfc_pkg::addr_t               buf_start;
  nfc_pkg::cnt_t                buf_remaining;
  nfc_pkg::cnt_t                buf_count;
  nfc_pkg::word_t               last_word;

  logic                         it_op;
  nfc_pkg::addr_t               it_addr;
  nfc_pkg::word_t               it_data;

  logic                         out_valid;
  nfc_pkg::word_t               out_rdata;
  nfc_pkg::mode_t               out_mode;
  logic                         out_failed;

  nfc_pkg::addr_t               sw_addr;
  nfc_pkg::addr_t               sw_last;
  nfc_pkg::cnt_t                cm_idx;
  logic                         cm_pend;
  nfc_pkg::addr_t               cm_addr;

  nfc_pkg::addr_t               arr_raddr;
  nfc_pkg::addr_t               arr_waddr;
  nfc_pkg::word_t               arr_wdata;
  logic                         arr_we;
  nfc_pkg::word_t               arr_q;
  nfc_pkg::word_t               buf_q;
  logic                         buf_we;

  nfc_pkg::mode_t               mode_next;
  nfc_pkg::cmd_act_t            act;
  nfc_pkg::cnt_t                remaining_next;
  nfc_pkg::word_t               rd_value;
  logic                         accept;
  logic                         cm_issue;

  assign accept    = req.valid && req.ready;
  assign req.ready = (phase == PH_IDLE) && (!out_valid || rsp.ready);
  assign cm_issue  = (phase == PH_COMMIT) && (cm_idx < buf_count);

  // Array memory: reads follow the request address, except during a commit.
  assign arr_raddr = cm_issue ? buf_start + nfc_pkg::ADDR_BITS'(cm_idx)
                              : nfc_pkg::ADDR_BITS'(req.word_addr);
  always_comb begin
    arr_we    = 1'b0;
    arr_waddr = sw_addr;
    arr_wdata = 16'hFFFF;
    if (phase == PH_CLEAR || phase == PH_ERASE) begin
      arr_we = 1'b1;
    end else if (phase == PH_COMMIT && cm_pend) begin
      arr_we    = 1'b1;
      arr_waddr = cm_addr;
      arr_wdata = arr_q & buf_q;
    end
  end

  nfc_ram #(.WIDTH(16), .DEPTH(nfc_pkg::ARRAY_WORDS)) u_array (
    .clk   (clk),
    .we    (arr_we),
    .waddr (arr_waddr),
    .wdata (arr_wdata),
    .raddr (arr_raddr),
    .rdata (arr_q)
  );

  // Write buffer: loaded during buffer load writes, read back by the commit.
  assign buf_we = (phase == PH_EXEC) && (it_op == nfc_pkg::OP_WRITE) && act.buf_wr;

  nfc_ram #(.WIDTH(16), .DEPTH(nfc_pkg::BUFFER_WORDS)) u_wbuf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (nfc_pkg::BUF_AW'(buf_count)),
    .wdata (it_data),
    .raddr (nfc_pkg::BUF_AW'(cm_idx)),
    .rdata (buf_q)
  );

  nfc_cmd u_cmd (
    .mode           (mode),
    .addr           (it_addr),
    .data           (it_data),
    .buf_start      (buf_start),
    .buf_count      (buf_count),
    .buf_remaining  (buf_remaining),
    .prot           (prot),
    .mode_next      (mode_next),
    .act            (act),
    .remaining_next (remaining_next)
  );

  // Read data selection by mode.
  always_comb begin
    rd_value = arr_q;
    if (nfc_pkg::is_abort(mode)) begin
      rd_value = {8'h00, ~last_word[7], 5'b00000, 1'b1, 1'b0};
    end else if (mode == nfc_pkg::M_AUTO) begin
      case (it_addr[7:0])
        nfc_pkg::AS_MFR:  rd_value = mfr_id;
        nfc_pkg::AS_DEV:  rd_value = dev_id;
        nfc_pkg::AS_PROT: rd_value = {15'b0, prot[nfc_pkg::block_of(it_addr)]};
        default:          rd_value = '0;
      endcase
    end else if (mode >= nfc_pkg::M_PROT && mode <= nfc_pkg::M_PEXIT) begin
      rd_value = {15'b0, !prot[nfc_pkg::block_of(it_addr)]};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mfr_id <= nfc_pkg::MFR_ID_RST;
      dev_id <= nfc_pkg::DEV_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        nfc_pkg::CFG_MFR_ID: mfr_id <= cfg_wdata;
        nfc_pkg::CFG_DEV_ID: dev_id <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      it_op   <= req.op;
      it_addr <= nfc_pkg::ADDR_BITS'(req.word_addr);
      it_data <= req.wdata;
    end
  end

  // Sequencer, command state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_CLEAR;
      mode          <= nfc_pkg::M_READ;
      prot          <= '0;
      buf_start     <= '0;
      buf_remaining <= '0;
      buf_count     <= '0;
      last_word     <= 16'hFFFF;
      sw_addr       <= '0;
      sw_last       <= '1;
      cm_idx        <= '0;
      cm_pend       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (phase)
        PH_CLEAR, PH_ERASE: begin
          if (sw_addr == sw_last) begin
            phase <= PH_IDLE;
          end else begin
            sw_addr <= sw_addr + nfc_pkg::ADDR_BITS'(1);
          end
        end
        PH_IDLE: begin
          if (accept) begin
            phase <= PH_EXEC;
          end
        end
        PH_EXEC: begin
          out_valid <= 1'b1;
          if (it_op == nfc_pkg::OP_READ) begin
            phase      <= PH_IDLE;
            out_rdata  <= rd_value;
            out_mode   <= mode;
            out_failed <= nfc_pkg::is_abort(mode);
          end else begin
            out_rdata  <= '0;
            mode       <= mode_next;
            out_mode   <= mode_next;
            out_failed <= nfc_pkg::is_abort(mode_next);
            if (act.lpw_ones) last_word <= 16'hFFFF;
            if (act.lpw_data) last_word <= it_data;
            if (act.set_start) buf_start <= it_addr;
            if (act.count_load) begin
              buf_remaining <= remaining_next;
              buf_count     <= '0;
            end
            if (act.count_step) begin
              buf_remaining <= remaining_next;
              buf_count     <= buf_count + nfc_pkg::CNT_W'(1);
            end
            if (act.prot_set) prot[nfc_pkg::block_of(it_addr)] <= 1'b1;
            if (act.prot_clear) prot <= '0;
            if (act.erase) begin
              phase   <= PH_ERASE;
              sw_addr <= (it_addr >> nfc_pkg::BLOCK_ADDR_BITS) << nfc_pkg::BLOCK_ADDR_BITS;
              sw_last <= ((it_addr >> nfc_pkg::BLOCK_ADDR_BITS) << nfc_pkg::BLOCK_ADDR_BITS)
                         | nfc_pkg::ADDR_BITS'((1 << nfc_pkg::BLOCK_ADDR_BITS) - 1);
            end else if (act.commit) begin
              phase   <= PH_COMMIT;
              cm_idx  <= '0;
              cm_pend <= 1'b0;
            end else begin
              phase <= PH_IDLE;
            end
          end
        end
        PH_COMMIT: begin
          // Read buffer and array word, AND them and write back in the next cycle.
          cm_pend <= cm_issue;
          if (cm_issue) begin
            cm_addr <= arr_raddr;
            cm_idx  <= cm_idx + nfc_pkg::CNT_W'(1);
          end else if (!cm_pend) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.rdata  = out_rdata;
  assign rsp.mode   = out_mode;
  assign rsp.failed = out_failed;
endmodule
`default_nettype wire

// File: hw/rtl/nfc_chk.sv
// Port-level checker for the NOR flash command block, bound to the top level.
// Depends on nfc_pkg and the assertion macro header.
`default_nettype none
`include "nor_flash_command_interface_top_assert.svh"
module nfc_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic [4:0] rsp_mode,
  input wire logic       rsp_failed
);
  // The failure flag agrees with the reported mode.
  `NFC_ASSERT(a_failed_mode, clk, rst, rsp_valid |-> (rsp_failed == nfc_pkg::is_abort(rsp_mode)), "failed flag disagrees with mode")
  // Reported modes stay within the defined set.
  `NFC_ASSERT(a_mode_range, clk, rst, rsp_valid |-> (rsp_mode <= nfc_pkg::M_AUL2), "mode out of range")
  // Reset empties the output register.
  `NFC_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !rsp_valid, "result valid after reset")
  // The clearing pass holds off requests right after reset.
  `NFC_ASSERT_ALWAYS(a_rst_ready, clk, rst |=> !req_ready, "request taken during clearing pass")
endmodule

bind nor_flash_command_interface_top nfc_chk u_nfc_chk (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_mode   (rsp.mode),
  .rsp_failed (rsp.failed)
);
`default_nettype wire
